>>> src/scc_pkg.sv
// Package for the network-name category classifier.
// Holds the category codes, the pattern table and shared helpers; no dependencies.
`default_nettype none

package scc_pkg;

  localparam int CNT_W     = 16;
  localparam int ROM_SIZE  = 61;
  localparam int ROM_CHARS = 11;
  localparam int CAT_COUNT = 8;

  typedef enum logic [2:0] {
    CAT_PERSONAL  = 3'd0,
    CAT_CORPORATE = 3'd1,
    CAT_HOTEL     = 3'd2,
    CAT_AIRPORT   = 3'd3,
    CAT_PROVIDER  = 3'd4,
    CAT_OPEN      = 3'd5,
    CAT_HIDDEN    = 3'd6,
    CAT_OTHER     = 3'd7
  } cat_t;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
    logic       hidden;
  } scc_byte_t;

  typedef struct packed {
    logic go;
    logic named;
    cat_t cat;
  } scc_event_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] named;
    logic [CNT_W-1:0] cat_total;
  } scc_counts_t;

  // Pattern text, first character in the top byte, zero padded.
  // Table is sorted by category.
  localparam logic [ROM_CHARS*8-1:0] ROM_TEXT [ROM_SIZE] = '{
    88'h69_70_68_6f_6e_65_00_00_00_00_00,
    88'h69_70_61_64_00_00_00_00_00_00_00,
    88'h6d_61_63_62_6f_6f_6b_00_00_00_00,
    88'h67_61_6c_61_78_79_00_00_00_00_00,
    88'h2d_70_69_78_65_6c_00_00_00_00_00,
    88'h5f_70_69_78_65_6c_00_00_00_00_00,
    88'h2d_6c_61_70_74_6f_70_00_00_00_00,
    88'h5f_6c_61_70_74_6f_70_00_00_00_00,
    88'h2d_70_68_6f_6e_65_00_00_00_00_00,
    88'h5f_70_68_6f_6e_65_00_00_00_00_00,
    88'h2d_70_63_00_00_00_00_00_00_00_00,
    88'h5f_70_63_00_00_00_00_00_00_00_00,
    88'h27_73_20_00_00_00_00_00_00_00_00,
    88'h27_73_5f_00_00_00_00_00_00_00_00,
    88'h2d_66_69_74_62_69_74_00_00_00_00,
    88'h2d_63_6f_72_70_00_00_00_00_00_00,
    88'h5f_63_6f_72_70_00_00_00_00_00_00,
    88'h63_6f_72_70_2d_00_00_00_00_00_00,
    88'h2d_69_6e_74_65_72_6e_61_6c_00_00,
    88'h5f_69_6e_74_65_72_6e_61_6c_00_00,
    88'h6f_66_66_69_63_65_2d_00_00_00_00,
    88'h67_6f_6f_67_6c_65_2d_00_00_00_00,
    88'h2d_6d_66_61_00_00_00_00_00_00_00,
    88'h2d_70_72_6f_64_00_00_00_00_00_00,
    88'h68_69_6c_74_6f_6e_00_00_00_00_00,
    88'h6d_61_72_72_69_6f_74_74_00_00_00,
    88'h68_79_61_74_74_00_00_00_00_00_00,
    88'h77_65_73_74_69_6e_00_00_00_00_00,
    88'h68_6f_6c_69_64_61_79_20_69_6e_6e,
    88'h68_6f_6c_69_64_61_79_69_6e_6e_00,
    88'h68_61_6d_70_74_6f_6e_00_00_00_00,
    88'h73_68_65_72_61_74_6f_6e_00_00_00,
    88'h69_68_67_00_00_00_00_00_00_00_00,
    88'h72_61_64_69_73_73_6f_6e_00_00_00,
    88'h68_6f_74_65_6c_2d_00_00_00_00_00,
    88'h68_6f_74_65_6c_5f_00_00_00_00_00,
    88'h5f_68_6f_74_65_6c_00_00_00_00_00,
    88'h61_69_72_70_6f_72_74_00_00_00_00,
    88'h5f_61_65_72_6f_00_00_00_00_00_00,
    88'h62_6f_69_6e_67_6f_00_00_00_00_00,
    88'h5f_6c_61_78_00_00_00_00_00_00_00,
    88'h5f_6a_66_6b_00_00_00_00_00_00_00,
    88'h5f_73_66_6f_00_00_00_00_00_00_00,
    88'h78_66_69_6e_69_74_79_00_00_00_00,
    88'h61_74_74_77_69_66_69_00_00_00_00,
    88'h65_64_75_72_6f_61_6d_00_00_00_00,
    88'h73_70_65_63_74_72_75_6d_00_00_00,
    88'h63_6f_6d_63_61_73_74_00_00_00_00,
    88'h76_65_72_69_7a_6f_6e_00_00_00_00,
    88'h63_6f_78_2d_77_69_66_69_00_00_00,
    88'h6f_70_74_69_6d_75_6d_2d_00_00_00,
    88'h67_75_65_73_74_00_00_00_00_00_00,
    88'h66_72_65_65_20_77_69_66_69_00_00,
    88'h66_72_65_65_5f_77_69_66_69_00_00,
    88'h70_75_62_6c_69_63_00_00_00_00_00,
    88'h76_69_73_69_74_6f_72_00_00_00_00,
    88'h68_6f_74_73_70_6f_74_00_00_00_00,
    88'h73_74_61_72_62_75_63_6b_73_00_00,
    88'h6d_63_64_6f_6e_61_6c_64_73_00_00,
    88'h74_61_72_67_65_74_5f_77_69_66_69,
    88'h5f_6f_70_65_6e_00_00_00_00_00_00
  };

  localparam logic [3:0] ROM_LEN [ROM_SIZE] = '{
    4'd6, 4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd6, 4'd6,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd5, 4'd5, 4'd5, 4'd9, 4'd9,
    4'd7, 4'd7, 4'd4, 4'd5, 4'd6, 4'd8, 4'd5, 4'd6, 4'd11, 4'd10,
    4'd7, 4'd8, 4'd3, 4'd8, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd6,
    4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd8, 4'd7, 4'd7, 4'd8,
    4'd8, 4'd5, 4'd9, 4'd9, 4'd6, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11,
    4'd5
  };

  localparam cat_t ROM_CAT [ROM_SIZE] = '{
    CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL,
    CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL,
    CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL, CAT_PERSONAL,
    CAT_CORPORATE, CAT_CORPORATE, CAT_CORPORATE, CAT_CORPORATE, CAT_CORPORATE,
    CAT_CORPORATE, CAT_CORPORATE, CAT_CORPORATE, CAT_CORPORATE,
    CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL,
    CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL, CAT_HOTEL,
    CAT_HOTEL,
    CAT_AIRPORT, CAT_AIRPORT, CAT_AIRPORT, CAT_AIRPORT, CAT_AIRPORT,
    CAT_AIRPORT,
    CAT_PROVIDER, CAT_PROVIDER, CAT_PROVIDER, CAT_PROVIDER, CAT_PROVIDER,
    CAT_PROVIDER, CAT_PROVIDER, CAT_PROVIDER,
    CAT_OPEN, CAT_OPEN, CAT_OPEN, CAT_OPEN, CAT_OPEN, CAT_OPEN, CAT_OPEN,
    CAT_OPEN, CAT_OPEN, CAT_OPEN
  };

  // Usable length of a pattern slot; 0 when the slot is empty or too long.
  function automatic int rom_len_of(int p, int max_len);
    int n;
    n = 0;
    if (p < ROM_SIZE) begin
      n = int'(ROM_LEN[p]);
    end
    if (n > max_len) begin
      n = 0;
    end
    return n;
  endfunction

  function automatic logic [7:0] rom_char_of(int p, int i);
    logic [7:0] ch;
    ch = 8'h00;
    if (p < ROM_SIZE && i < ROM_CHARS) begin
      ch = ROM_TEXT[p][(ROM_CHARS-1-i)*8 +: 8];
    end
    return ch;
  endfunction

  function automatic cat_t rom_cat_of(int p);
    cat_t c;
    c = CAT_OTHER;
    if (p < ROM_SIZE) begin
      c = ROM_CAT[p];
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/scc_match.sv
// Shift-and pattern tracker: progress vectors and seen bits for every pattern.
// Depends on scc_pkg for the pattern table and category codes.
`default_nettype none

module scc_match import scc_pkg::*; #(
  parameter int PATTERN_COUNT   = 61,
  parameter int MAX_PATTERN_LEN = 11
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      go,
  input  wire scc_byte_t item,
  output cat_t           cat
);

  logic [MAX_PATTERN_LEN-1:0] prog      [PATTERN_COUNT];
  logic [MAX_PATTERN_LEN-1:0] prog_next [PATTERN_COUNT];
  logic [PATTERN_COUNT-1:0]   seen;
  logic [PATTERN_COUNT-1:0]   hit;
  logic [PATTERN_COUNT-1:0]   seen_next;
  logic [7:0]                 folded;
  logic [CAT_COUNT-1:0]       cat_hit;

  assign folded = (item.name_byte >= ASCII_UPPER_A && item.name_byte <= ASCII_UPPER_Z) ?
                  (item.name_byte | ASCII_CASE) : item.name_byte;

  for (genvar p = 0; p < PATTERN_COUNT; p++) begin : g_pat
    localparam int LEN = rom_len_of(p, MAX_PATTERN_LEN);
    if (LEN == 0) begin : g_unused
      assign prog_next[p] = '0;
      assign hit[p]       = 1'b0;
    end else begin : g_used
      logic [MAX_PATTERN_LEN-1:0] eq;
      for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_chr
        localparam logic [7:0] CH = rom_char_of(p, i);
        if (i < LEN) begin : g_cmp
          assign eq[i] = (folded == CH);
        end else begin : g_pad
          assign eq[i] = 1'b0;
        end
      end
      assign prog_next[p] = MAX_PATTERN_LEN'({prog[p], 1'b1}) & eq;
      assign hit[p]       = prog_next[p][LEN-1];
    end
  end

  assign seen_next = seen | hit;

  // Table is sorted by category, so the first pattern hit is the lowest category hit.
  always_comb begin
    cat_hit = '0;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      if (seen_next[p]) begin
        cat_hit[rom_cat_of(p)] = 1'b1;
      end
    end
  end

  always_comb begin
    cat = CAT_OTHER;
    for (int c = int'(CAT_HIDDEN) - 1; c >= 0; c--) begin
      if (cat_hit[c]) begin
        cat = cat_t'(3'(c));
      end
    end
    if (item.hidden) begin
      cat = CAT_HIDDEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int p = 0; p < PATTERN_COUNT; p++) begin
        prog[p] <= '0;
      end
    end else if (go) begin
      if (item.hidden || item.last_byte) begin
        seen <= '0;
        for (int p = 0; p < PATTERN_COUNT; p++) begin
          prog[p] <= '0;
        end
      end else begin
        seen <= seen_next;
        for (int p = 0; p < PATTERN_COUNT; p++) begin
          prog[p] <= prog_next[p];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/scc_stats.sv
// Saturating probe counters: all names, non-empty names and names per category.
// Depends on scc_pkg for counter width, event and count structs.
`default_nettype none

module scc_stats import scc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire scc_event_t ev,
  output scc_counts_t     counts
);

  logic [CNT_W-1:0] all_count;
  logic [CNT_W-1:0] named_count;
  logic [CNT_W-1:0] per_cat [CAT_COUNT];
  logic [2:0]       idx;

  assign idx              = ev.cat;
  assign counts.total     = sat_inc(all_count);
  assign counts.named     = ev.named ? sat_inc(named_count) : named_count;
  assign counts.cat_total = sat_inc(per_cat[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      all_count   <= '0;
      named_count <= '0;
      for (int c = 0; c < CAT_COUNT; c++) begin
        per_cat[c] <= '0;
      end
    end else if (ev.go) begin
      all_count    <= counts.total;
      named_count  <= counts.named;
      per_cat[idx] <= counts.cat_total;
    end
  end

endmodule

`default_nettype wire

>>> src/ssid_category_classifier_core.sv
// Top level of the network-name category classifier.
// Depends on scc_pkg, scc_match and scc_stats.
//
// Usage:
//   A name arrives as a run of items on the name channel (name_valid /
//   name_ready), one byte each; last_byte marks the final byte. An item
//   with hidden set stands for an empty name and finishes a probe alone,
//   dropping any partial name in progress.
//   Each finished name yields one item on the result channel
//   (result_valid / result_ready): category plus saturating counts of all
//   names, non-empty names and names of that category, after this one.
//   A finishing item is held in the input register, and its result is
//   written to the result register once that is free. Throughput: one
//   item per cycle while no finishing item waits; every pattern is updated
//   in parallel between the input register and the result register.
//   A stalled result holds; non-final bytes keep flowing past it, and only
//   a finishing item waits until the result register is free.
//   Reset clears match state, counters and both valid flags.
`default_nettype none

module ssid_category_classifier_core import scc_pkg::*; #(
  parameter int PATTERN_COUNT   = 61,
  parameter int MAX_PATTERN_LEN = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             name_valid,
  output logic                  name_ready,
  input  wire logic [7:0]       name_byte,
  input  wire logic             last_byte,
  input  wire logic             hidden,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [2:0]            category,
  output logic [CNT_W-1:0]      total_probes,
  output logic [CNT_W-1:0]      directed_probes,
  output logic [CNT_W-1:0]      category_total
);

  logic        s1_valid;
  scc_byte_t   s1;
  logic        s1_done;
  logic        out_free;
  logic        s1_go;
  cat_t        cat;
  scc_event_t  ev;
  scc_counts_t counts;

  assign s1_done    = s1.hidden | s1.last_byte;
  assign out_free   = !result_valid | result_ready;
  assign s1_go      = s1_valid & (!s1_done | out_free);
  assign name_ready = !s1_valid | s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (name_ready) begin
      s1_valid <= name_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (name_ready && name_valid) begin
      s1.name_byte <= name_byte;
      s1.last_byte <= last_byte;
      s1.hidden    <= hidden;
    end
  end

  scc_match #(
    .PATTERN_COUNT  (PATTERN_COUNT),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_match (
    .clk (clk),
    .rst (rst),
    .go  (s1_go),
    .item(s1),
    .cat (cat)
  );

  assign ev.go    = s1_go & s1_done;
  assign ev.named = !s1.hidden;
  assign ev.cat   = cat;

  scc_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .ev    (ev),
    .counts(counts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ev.go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.go) begin
      category        <= cat;
      total_probes    <= counts.total;
      directed_probes <= counts.named;
      category_total  <= counts.cat_total;
    end
  end

endmodule

`default_nettype wire

>>> src/scc_checker.sv
// Port-level checks for the classifier, bound to the top level.
// Depends on the ports of ssid_category_classifier_core only.
`default_nettype none

module scc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [2:0]  category,
  input wire logic [15:0] total_probes,
  input wire logic [15:0] directed_probes,
  input wire logic [15:0] category_total
);

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(category)
      && $stable(total_probes) && $stable(category_total))
    else $error("stalled result changed");

  a_named_le_total: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> directed_probes <= total_probes)
    else $error("non-empty count exceeds total count");

  a_cat_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> category_total != 16'd0 && category_total <= total_probes)
    else $error("category count out of range");

endmodule

bind ssid_category_classifier_core scc_checker u_scc_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .category       (category),
  .total_probes   (total_probes),
  .directed_probes(directed_probes),
  .category_total (category_total)
);

`default_nettype wire

>>> tb/scc_probe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for ssid_category_classifier_core: watches both channels, classifies each name
// with its own pattern table and compares every result field. Depends on scc_pkg (cat_t).

module scc_probe_checker import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        name_valid,
  input  wire logic        name_ready,
  input  wire logic [7:0]  name_byte,
  input  wire logic        last_byte,
  input  wire logic        hidden,
  input  wire logic        result_valid,
  input  wire logic        result_ready,
  input  wire logic [2:0]  category,
  input  wire logic [15:0] total_probes,
  input  wire logic [15:0] directed_probes,
  input  wire logic [15:0] category_total,
  output int               errors,
  output int               pending
);

  localparam int PATTERNS = 61;

  // Pattern text, first character in the top byte, zero padded.
  localparam logic [87:0] PAT_TEXT [PATTERNS] = '{
    88'h69_70_68_6f_6e_65_00_00_00_00_00, 88'h69_70_61_64_00_00_00_00_00_00_00,
    88'h6d_61_63_62_6f_6f_6b_00_00_00_00, 88'h67_61_6c_61_78_79_00_00_00_00_00,
    88'h2d_70_69_78_65_6c_00_00_00_00_00, 88'h5f_70_69_78_65_6c_00_00_00_00_00,
    88'h2d_6c_61_70_74_6f_70_00_00_00_00, 88'h5f_6c_61_70_74_6f_70_00_00_00_00,
    88'h2d_70_68_6f_6e_65_00_00_00_00_00, 88'h5f_70_68_6f_6e_65_00_00_00_00_00,
    88'h2d_70_63_00_00_00_00_00_00_00_00, 88'h5f_70_63_00_00_00_00_00_00_00_00,
    88'h27_73_20_00_00_00_00_00_00_00_00, 88'h27_73_5f_00_00_00_00_00_00_00_00,
    88'h2d_66_69_74_62_69_74_00_00_00_00,
    88'h2d_63_6f_72_70_00_00_00_00_00_00, 88'h5f_63_6f_72_70_00_00_00_00_00_00,
    88'h63_6f_72_70_2d_00_00_00_00_00_00, 88'h2d_69_6e_74_65_72_6e_61_6c_00_00,
    88'h5f_69_6e_74_65_72_6e_61_6c_00_00, 88'h6f_66_66_69_63_65_2d_00_00_00_00,
    88'h67_6f_6f_67_6c_65_2d_00_00_00_00, 88'h2d_6d_66_61_00_00_00_00_00_00_00,
    88'h2d_70_72_6f_64_00_00_00_00_00_00,
    88'h68_69_6c_74_6f_6e_00_00_00_00_00, 88'h6d_61_72_72_69_6f_74_74_00_00_00,
    88'h68_79_61_74_74_00_00_00_00_00_00, 88'h77_65_73_74_69_6e_00_00_00_00_00,
    88'h68_6f_6c_69_64_61_79_20_69_6e_6e, 88'h68_6f_6c_69_64_61_79_69_6e_6e_00,
    88'h68_61_6d_70_74_6f_6e_00_00_00_00, 88'h73_68_65_72_61_74_6f_6e_00_00_00,
    88'h69_68_67_00_00_00_00_00_00_00_00, 88'h72_61_64_69_73_73_6f_6e_00_00_00,
    88'h68_6f_74_65_6c_2d_00_00_00_00_00, 88'h68_6f_74_65_6c_5f_00_00_00_00_00,
    88'h5f_68_6f_74_65_6c_00_00_00_00_00,
    88'h61_69_72_70_6f_72_74_00_00_00_00, 88'h5f_61_65_72_6f_00_00_00_00_00_00,
    88'h62_6f_69_6e_67_6f_00_00_00_00_00, 88'h5f_6c_61_78_00_00_00_00_00_00_00,
    88'h5f_6a_66_6b_00_00_00_00_00_00_00, 88'h5f_73_66_6f_00_00_00_00_00_00_00,
    88'h78_66_69_6e_69_74_79_00_00_00_00, 88'h61_74_74_77_69_66_69_00_00_00_00,
    88'h65_64_75_72_6f_61_6d_00_00_00_00, 88'h73_70_65_63_74_72_75_6d_00_00_00,
    88'h63_6f_6d_63_61_73_74_00_00_00_00, 88'h76_65_72_69_7a_6f_6e_00_00_00_00,
    88'h63_6f_78_2d_77_69_66_69_00_00_00, 88'h6f_70_74_69_6d_75_6d_2d_00_00_00,
    88'h67_75_65_73_74_00_00_00_00_00_00, 88'h66_72_65_65_20_77_69_66_69_00_00,
    88'h66_72_65_65_5f_77_69_66_69_00_00, 88'h70_75_62_6c_69_63_00_00_00_00_00,
    88'h76_69_73_69_74_6f_72_00_00_00_00, 88'h68_6f_74_73_70_6f_74_00_00_00_00,
    88'h73_74_61_72_62_75_63_6b_73_00_00, 88'h6d_63_64_6f_6e_61_6c_64_73_00_00,
    88'h74_61_72_67_65_74_5f_77_69_66_69, 88'h5f_6f_70_65_6e_00_00_00_00_00_00
  };

  // Table is grouped by category; entry k marks the end of category k.
  localparam int CAT_END [6] = '{15, 24, 37, 43, 51, 61};

  typedef struct packed {
    cat_t        cat;
    logic [15:0] total;
    logic [15:0] named;
    logic [15:0] cat_total;
  } probe_report_t;

  probe_report_t probe_reports [$];
  logic [10:0]   progress [PATTERNS];
  bit            seen [PATTERNS];
  logic [15:0]   per_category [8];
  logic [15:0]   names_all;
  logic [15:0]   names_named;
  int            mismatches = 0;

  task automatic classify_name_byte(input logic [7:0] b, input logic fin, input logic hid);
    probe_report_t rep;
    cat_t          c;
    logic [7:0]    ch;
    logic [10:0]   hits;
    logic [10:0]   nxt;
    int            n;
    if (hid) begin
      c = CAT_HIDDEN;
      if (names_all != 16'hffff) names_all++;
    end else begin
      ch = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
      for (int p = 0; p < PATTERNS; p++) begin
        n = 0;
        hits = '0;
        while (n < 11 && PAT_TEXT[p][87 - 8*n -: 8] != 8'h00) begin
          hits[n] = (PAT_TEXT[p][87 - 8*n -: 8] == ch);
          n++;
        end
        nxt = {progress[p][9:0], 1'b1} & hits;
        progress[p] = nxt;
        if (nxt[n-1]) seen[p] = 1'b1;
      end
      if (!fin) return;
      c = CAT_OTHER;
      for (int p = PATTERNS - 1; p >= 0; p--) begin
        if (seen[p]) begin
          for (int k = 5; k >= 0; k--) begin
            if (p < CAT_END[k]) c = cat_t'(k);
          end
        end
      end
      if (names_all != 16'hffff) names_all++;
      if (names_named != 16'hffff) names_named++;
    end
    for (int p = 0; p < PATTERNS; p++) begin
      progress[p] = '0;
      seen[p] = 1'b0;
    end
    if (per_category[c] != 16'hffff) per_category[c]++;
    rep.cat = c;
    rep.total = names_all;
    rep.named = names_named;
    rep.cat_total = per_category[c];
    probe_reports.push_back(rep);
  endtask

  always @(posedge clk) begin : watch
    probe_report_t want;
    if (rst) begin
      probe_reports.delete();
      for (int p = 0; p < PATTERNS; p++) begin
        progress[p] = '0;
        seen[p] = 1'b0;
      end
      for (int k = 0; k < 8; k++) per_category[k] = '0;
      names_all = '0;
      names_named = '0;
    end else begin
      if (name_valid && name_ready) classify_name_byte(name_byte, last_byte, hidden);
      if (result_valid && result_ready) begin
        if (probe_reports.size() == 0) begin
          $error("unexpected result item: category %0d total %0d", category, total_probes);
          mismatches++;
        end else begin
          want = probe_reports.pop_front();
          if (category !== want.cat) begin
            $error("category: expected %0d, actual %0d", want.cat, category);
            mismatches++;
          end
          if (total_probes !== want.total) begin
            $error("total_probes: expected %0d, actual %0d", want.total, total_probes);
            mismatches++;
          end
          if (directed_probes !== want.named) begin
            $error("directed_probes: expected %0d, actual %0d", want.named, directed_probes);
            mismatches++;
          end
          if (category_total !== want.cat_total) begin
            $error("category_total: expected %0d, actual %0d", want.cat_total, category_total);
            mismatches++;
          end
        end
      end
    end
    errors <= mismatches;
    pending <= probe_reports.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the classifier testbench: clock, reset, name stimulus, result back-pressure, verdict.
// Depends on scc_pkg, ssid_category_classifier_core and scc_probe_checker.

module testbench import scc_pkg::*; ;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        name_valid = 1'b0;
  logic [7:0]  name_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        hidden = 1'b0;
  logic        result_ready = 1'b0;
  wire logic   name_ready;
  wire logic   result_valid;
  wire logic [2:0]  category;
  wire logic [15:0] total_probes;
  wire logic [15:0] directed_probes;
  wire logic [15:0] category_total;
  int          errors;
  int          pending;

  bit          calm = 1'b0;
  int          hold_request = 0;
  int          sent = 0;
  int          quiet = 0;
  logic [7:0]  word [$];

  ssid_category_classifier_core dut (.*);
  scc_probe_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (name_valid && name_ready) || (result_valid && result_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (calm) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  function automatic logic [7:0] random_case(logic [7:0] ch);
    if (ch >= "a" && ch <= "z" && $urandom_range(1)) return ch - 8'h20;
    return ch;
  endfunction

  function automatic logic [7:0] filler_byte();
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyz0123456789-_' ";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return random_case(alphabet[$urandom_range(alphabet.len() - 1)]);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic fin, input logic hid);
    while (!calm && $urandom_range(99) < 34) begin
      name_valid <= 1'b0;
      @(posedge clk);
    end
    name_valid <= 1'b1;
    name_byte <= b;
    last_byte <= fin;
    hidden <= hid;
    @(posedge clk);
    while (!name_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_name(input bit fin);
    for (int i = 0; i < word.size(); i++) begin
      send_item(word[i], fin && (i == word.size() - 1), 1'b0);
    end
  endtask

  task automatic send_text(input string s);
    word.delete();
    for (int i = 0; i < s.len(); i++) word.push_back(s[i]);
    send_name(1'b1);
  endtask

  initial begin : stimulus
    int kind;
    int p;
    int n;
    int base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty names, extreme bytes, case folding, dropped partial name, table order
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_text("IhG");
    send_text("-MFA");
    send_item("_", 1'b0, 1'b0);
    send_item("j", 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
    send_text("_JFK");
    send_text("GUEST_pc");

    // random names; results held off at the start so the block backs up
    base = sent;
    hold_request = 400;
    while (sent < base + 900) begin
      calm = (sent >= base + 350 && sent < base + 550);
      kind = $urandom_range(99);
      word.delete();
      if (kind >= 70 && kind < 80) begin
        repeat ($urandom_range(1, 12)) word.push_back(8'($urandom_range(255)));
      end else if (kind < 70 || kind >= 90) begin
        repeat ($urandom_range(0, 2)) word.push_back(filler_byte());
        repeat (kind < 70 ? $urandom_range(1, 3) : 1) begin
          p = $urandom_range(ROM_SIZE - 1);
          n = int'(ROM_LEN[p]);
          if (kind >= 90 || $urandom_range(4) == 0) n--;
          for (int i = 0; i < n; i++) begin
            word.push_back(random_case(ROM_TEXT[p][(ROM_CHARS - 1 - i) * 8 +: 8]));
          end
          repeat ($urandom_range(0, 2)) word.push_back(filler_byte());
        end
      end
      if (kind < 80) begin
        send_name(1'b1);
      end else begin
        send_name(1'b0);
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
    end
    calm = 1'b0;

    name_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> ssid_category_classifier_core.f
src/scc_pkg.sv
src/scc_match.sv
src/scc_stats.sv
src/ssid_category_classifier_core.sv
src/scc_checker.sv
tb/scc_probe_checker.sv
tb/testbench.sv
